/* rtl/utf8v_pkg.sv */
package utf8v_pkg;

	localparam int unsigned CpW = 21;

	localparam logic [CpW-1:0] CpMax       = 21'h10FFFF;
	localparam logic [CpW-1:0] SurrLo      = 21'h00D800;
	localparam logic [CpW-1:0] SurrHi      = 21'h00DFFF;
	localparam logic [CpW-1:0] OneByteMax  = 21'h00007F;
	localparam logic [CpW-1:0] TwoByteMax  = 21'h0007FF;
	localparam logic [CpW-1:0] ThreeByteMax = 21'h00FFFF;
	localparam logic [CpW-1:0] C0End       = 21'h000020;
	localparam logic [CpW-1:0] DelCode     = 21'h00007F;
	localparam logic [CpW-1:0] C1Max       = 21'h00009F;

	localparam logic [2:0] Len1 = 3'd1;
	localparam logic [2:0] Len2 = 3'd2;
	localparam logic [2:0] Len3 = 3'd3;
	localparam logic [2:0] Len4 = 3'd4;

	typedef struct packed {
		logic [1:0]     bytes_remaining;
		logic [2:0]     sequence_length;
		logic [CpW-1:0] code_accum;
		logic           error_seen;
		logic           control_seen;
	} dec_state_t;

	typedef struct packed {
		logic invalid;
		logic has_control;
		logic message_done;
	} verdict_t;

	localparam dec_state_t StateClear = '0;

endpackage

/* rtl/utf8v_in_if.sv */
interface utf8v_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_last;

	modport source (output valid, output data_byte, output is_last, input ready);
	modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

/* rtl/utf8v_out_if.sv */
interface utf8v_out_if;
	logic valid;
	logic ready;
	logic invalid;
	logic has_control;
	logic message_done;

	modport source (output valid, output invalid, output has_control, output message_done,
		input ready);
	modport sink (input valid, input invalid, input has_control, input message_done,
		output ready);
endinterface

/* rtl/utf8v_step.sv */
module utf8v_step
	import utf8v_pkg::*;
(
	input  dec_state_t cur,
	input  logic [7:0] data_byte,
	input  logic       is_last,
	output dec_state_t nxt,
	output verdict_t   verdict
);

	function automatic logic cp_ok(input logic [CpW-1:0] cp, input logic [2:0] len);
		logic ok;
		begin
			if (cp > CpMax) begin
				ok = 1'b0;
			end else if (cp >= SurrLo && cp <= SurrHi) begin
				ok = 1'b0;
			end else if (cp <= OneByteMax) begin
				ok = (len == Len1);
			end else if (cp <= TwoByteMax) begin
				ok = (len == Len2);
			end else if (cp <= ThreeByteMax) begin
				ok = (len == Len3);
			end else begin
				ok = (len == Len4);
			end
			return ok;
		end
	endfunction

	function automatic logic is_ctrl(input logic [CpW-1:0] cp);
		return (cp < C0End) || (cp >= DelCode && cp <= C1Max);
	endfunction

	logic [CpW-1:0] shifted;
	logic [1:0]     rem_dec;

	always_comb begin
		shifted = {cur.code_accum[CpW-7:0], data_byte[5:0]};
		rem_dec = cur.bytes_remaining - 2'd1;
		nxt     = cur;
		if (!cur.error_seen) begin
			if (cur.bytes_remaining == 2'd0) begin
				if (data_byte[7] == 1'b0) begin
					nxt.sequence_length = Len1;
					nxt.code_accum      = {{(CpW-8){1'b0}}, data_byte};
					if (!cp_ok(nxt.code_accum, Len1)) begin
						nxt.error_seen = 1'b1;
					end else if (is_ctrl(nxt.code_accum)) begin
						nxt.control_seen = 1'b1;
					end
				end else if (data_byte[7:5] == 3'b110) begin
					nxt.sequence_length = Len2;
					nxt.bytes_remaining = 2'd1;
					nxt.code_accum      = {{(CpW-5){1'b0}}, data_byte[4:0]};
				end else if (data_byte[7:4] == 4'b1110) begin
					nxt.sequence_length = Len3;
					nxt.bytes_remaining = 2'd2;
					nxt.code_accum      = {{(CpW-4){1'b0}}, data_byte[3:0]};
				end else if (data_byte[7:3] == 5'b11110) begin
					nxt.sequence_length = Len4;
					nxt.bytes_remaining = 2'd3;
					nxt.code_accum      = {{(CpW-3){1'b0}}, data_byte[2:0]};
				end else begin
					nxt.error_seen = 1'b1;
				end
			end else if (data_byte[7:6] != 2'b10) begin
				nxt.error_seen = 1'b1;
			end else begin
				nxt.code_accum      = shifted;
				nxt.bytes_remaining = rem_dec;
				if (rem_dec == 2'd0) begin
					if (!cp_ok(shifted, cur.sequence_length)) begin
						nxt.error_seen = 1'b1;
					end else if (is_ctrl(shifted)) begin
						nxt.control_seen = 1'b1;
					end
				end
			end
			if (is_last && nxt.bytes_remaining != 2'd0) begin
				nxt.error_seen = 1'b1;
			end
		end
		verdict.invalid      = nxt.error_seen;
		verdict.has_control  = nxt.control_seen;
		verdict.message_done = is_last;
		if (is_last) begin
			nxt = StateClear;
		end
	end

endmodule

/* rtl/utf8_validator_ctrl_detect_core.sv */
// The result beat of an accepted input beat is valid in the cycle after acceptance.
// Throughput: one byte per cycle unless stalled; decode state updates on acceptance.
// A stalled result beat holds the input off until downstream takes it.
// Reset: arst_n clears the decode state and the result valid at once; no clearing pass.
module utf8_validator_ctrl_detect_core
	import utf8v_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	utf8v_in_if.sink   din,
	utf8v_out_if.source dout
);

	dec_state_t state_q;
	dec_state_t state_nxt;
	verdict_t   verdict;
	verdict_t   result_q;
	logic       valid_q;
	logic       take;

	utf8v_step u_step (
		.cur       (state_q),
		.data_byte (din.data_byte),
		.is_last   (din.is_last),
		.nxt       (state_nxt),
		.verdict   (verdict)
	);

	assign din.ready = !valid_q || dout.ready;
	assign take      = din.valid && din.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StateClear;
			valid_q <= 1'b0;
		end else begin
			if (take) begin
				state_q <= state_nxt;
				valid_q <= 1'b1;
			end else if (dout.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= verdict;
		end
	end

	assign dout.valid        = valid_q;
	assign dout.invalid      = result_q.invalid;
	assign dout.has_control  = result_q.has_control;
	assign dout.message_done = result_q.message_done;

endmodule

/* rtl/utf8v_checker.sv */
module utf8v_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] data_byte,
	input logic       is_last,
	input logic       out_valid,
	input logic       out_ready,
	input logic       invalid,
	input logic       has_control,
	input logic       message_done
);

	logic in_beat;
	assign in_beat = in_valid && in_ready;

	a_free_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	a_beat_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> out_valid && (message_done == $past(is_last)))
		else $error("result beat missing or wrong message end mark");

	a_cut_leader: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && is_last && data_byte >= 8'hC0 && data_byte <= 8'hF7 |=> invalid)
		else $error("message ending on a multi-byte leader not flagged");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(invalid) && $stable(has_control)
		&& $stable(message_done))
		else $error("stalled result beat changed");

endmodule

bind utf8_validator_ctrl_detect_core utf8v_checker u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (din.valid),
	.in_ready     (din.ready),
	.data_byte    (din.data_byte),
	.is_last      (din.is_last),
	.out_valid    (dout.valid),
	.out_ready    (dout.ready),
	.invalid      (dout.invalid),
	.has_control  (dout.has_control),
	.message_done (dout.message_done)
);

/* sim/utf8_validator_ctrl_detect_core_test.sv */
module utf8_validator_ctrl_detect_core_test
	import utf8v_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned PhaseBytes = 475;

	typedef enum int unsigned {
		FaultNone,
		FaultOverlong,
		FaultSurrogate,
		FaultAboveMax,
		FaultLeader,
		FaultContinuation,
		FaultTruncate
	} fault_e;

	logic clk;
	logic arst_n;

	utf8v_in_if  byte_in ();
	utf8v_out_if verdict_out ();

	utf8_validator_ctrl_detect_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (byte_in),
		.dout   (verdict_out)
	);

	verdict_t    verdict_q[$];
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned cycle_count = 0;
	int unsigned mismatches;
	int unsigned results_seen;
	int unsigned bytes_sent;
	int unsigned msgs_sent;
	int unsigned msgs_rejected;
	int unsigned msgs_control;

	logic [1:0]     pend_cont;
	logic [2:0]     cur_len;
	logic [CpW-1:0] cp_acc;
	logic           err_flag;
	logic           ctl_flag;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("utf8_validator_ctrl_detect_core_test: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		verdict_out.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic logic code_point_legal(input logic [CpW-1:0] cp, input logic [2:0] len);
		if (cp > CpMax)
			return 1'b0;
		if (cp >= SurrLo && cp <= SurrHi)
			return 1'b0;
		if (cp <= OneByteMax)
			return len == Len1;
		if (cp <= TwoByteMax)
			return len == Len2;
		if (cp <= ThreeByteMax)
			return len == Len3;
		return len == Len4;
	endfunction

	function automatic void close_char(input logic [CpW-1:0] cp, input logic [2:0] len);
		if (!code_point_legal(cp, len))
			err_flag = 1'b1;
		else if (cp < C0End || (cp >= DelCode && cp <= C1Max))
			ctl_flag = 1'b1;
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic last, output verdict_t v);
		if (!err_flag) begin
			if (pend_cont == 2'd0) begin
				if (!b[7]) begin
					cur_len = Len1;
					cp_acc = {{(CpW-8){1'b0}}, b};
					close_char(cp_acc, Len1);
				end else if (b[7:5] == 3'b110) begin
					cur_len = Len2;
					pend_cont = 2'd1;
					cp_acc = {{(CpW-5){1'b0}}, b[4:0]};
				end else if (b[7:4] == 4'b1110) begin
					cur_len = Len3;
					pend_cont = 2'd2;
					cp_acc = {{(CpW-4){1'b0}}, b[3:0]};
				end else if (b[7:3] == 5'b11110) begin
					cur_len = Len4;
					pend_cont = 2'd3;
					cp_acc = {{(CpW-3){1'b0}}, b[2:0]};
				end else begin
					err_flag = 1'b1;
				end
			end else if (b[7:6] != 2'b10) begin
				err_flag = 1'b1;
			end else begin
				cp_acc = {cp_acc[CpW-7:0], b[5:0]};
				pend_cont = pend_cont - 2'd1;
				if (pend_cont == 2'd0)
					close_char(cp_acc, cur_len);
			end
			if (last && pend_cont != 2'd0)
				err_flag = 1'b1;
		end
		v.invalid = err_flag;
		v.has_control = ctl_flag;
		v.message_done = last;
		if (last) begin
			pend_cont = '0;
			cur_len = '0;
			cp_acc = '0;
			err_flag = 1'b0;
			ctl_flag = 1'b0;
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at result %0d (cycle %0d): %s", results_seen, cycle_count, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_beat
		verdict_t want;
		if (arst_n && verdict_out.valid && verdict_out.ready) begin
			if (verdict_q.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				want = verdict_q.pop_front();
				if (verdict_out.invalid !== want.invalid)
					report_mismatch($sformatf("invalid got %b want %b",
						verdict_out.invalid, want.invalid));
				if (verdict_out.has_control !== want.has_control)
					report_mismatch($sformatf("has_control got %b want %b",
						verdict_out.has_control, want.has_control));
				if (verdict_out.message_done !== want.message_done)
					report_mismatch($sformatf("message_done got %b want %b",
						verdict_out.message_done, want.message_done));
			end
			results_seen++;
		end
	end

	task automatic send_beat(input logic [7:0] b, input logic last);
		verdict_t v;
		while ($urandom_range(99) < send_idle_pct) begin
			byte_in.valid <= 1'b0;
			@(posedge clk);
		end
		byte_in.valid <= 1'b1;
		byte_in.data_byte <= b;
		byte_in.is_last <= last;
		@(posedge clk);
		while (!byte_in.ready)
			@(posedge clk);
		decode_byte(b, last, v);
		verdict_q = {verdict_q, v};
		bytes_sent++;
		if (last) begin
			msgs_sent++;
			if (v.invalid)
				msgs_rejected++;
			if (v.has_control)
				msgs_control++;
		end
	endtask

	task automatic wait_for_results();
		byte_in.valid <= 1'b0;
		do
			@(posedge clk);
		while (verdict_q.size() != 0);
	endtask

	task automatic send_char(input logic [CpW-1:0] cp, input int len, input int keep,
		input logic last);
		logic [7:0] enc[4];
		case (len)
			1: begin
				enc[0] = {1'b0, cp[6:0]};
			end
			2: begin
				enc[0] = {3'b110, cp[10:6]};
				enc[1] = {2'b10, cp[5:0]};
			end
			3: begin
				enc[0] = {4'b1110, cp[15:12]};
				enc[1] = {2'b10, cp[11:6]};
				enc[2] = {2'b10, cp[5:0]};
			end
			default: begin
				enc[0] = {5'b11110, cp[20:18]};
				enc[1] = {2'b10, cp[17:12]};
				enc[2] = {2'b10, cp[11:6]};
				enc[3] = {2'b10, cp[5:0]};
			end
		endcase
		for (int i = 0; i < keep; i++)
			send_beat(enc[i], last && i == keep - 1);
	endtask

	task automatic pick_char(output logic [CpW-1:0] cp, output int len);
		case ($urandom_range(11))
			0, 1, 2, 3: begin
				cp = CpW'($urandom_range(8'h7E, 8'h20));
				len = 1;
			end
			4: begin
				cp = $urandom_range(1) ? CpW'($urandom_range(8'h1F, 0)) : DelCode;
				len = 1;
			end
			5: begin
				cp = CpW'($urandom_range(C1Max, OneByteMax + 1));
				len = 2;
			end
			6, 7: begin
				cp = CpW'($urandom_range(TwoByteMax, C1Max + 1));
				len = 2;
			end
			8, 9: begin
				cp = CpW'($urandom_range(ThreeByteMax, TwoByteMax + 1));
				if (cp >= SurrLo && cp <= SurrHi)
					cp[13] = 1'b1;
				len = 3;
			end
			10: begin
				cp = CpW'($urandom_range(CpMax, ThreeByteMax + 1));
				len = 4;
			end
			default: begin
				case ($urandom_range(9))
					0: cp = '0;
					1: cp = OneByteMax;
					2: cp = OneByteMax + 1;
					3: cp = TwoByteMax;
					4: cp = TwoByteMax + 1;
					5: cp = SurrLo - 1;
					6: cp = SurrHi + 1;
					7: cp = ThreeByteMax;
					8: cp = ThreeByteMax + 1;
					default: cp = CpMax;
				endcase
				if (cp <= OneByteMax)
					len = 1;
				else if (cp <= TwoByteMax)
					len = 2;
				else if (cp <= ThreeByteMax)
					len = 3;
				else
					len = 4;
			end
		endcase
	endtask

	task automatic random_message();
		int          n_chars;
		int          fault_at;
		int          len;
		logic [CpW-1:0] cp;
		logic [7:0]  b;
		logic        last;
		fault_e      fault;
		n_chars = int'($urandom_range(8, 1));
		if ($urandom_range(9) == 0) begin
			for (int i = 0; i < n_chars; i++)
				send_beat(8'($urandom_range(255)), i == n_chars - 1);
		end else begin
			fault_at = ($urandom_range(9) < 7) ? -1 : int'($urandom_range(n_chars - 1));
			for (int i = 0; i < n_chars; i++) begin
				last = (i == n_chars - 1);
				pick_char(cp, len);
				fault = (i == fault_at) ? fault_e'($urandom_range(FaultTruncate, FaultOverlong))
					: FaultNone;
				if ((fault == FaultContinuation || fault == FaultTruncate) && len == 1) begin
					cp = CpW'($urandom_range(TwoByteMax, OneByteMax + 1));
					len = 2;
				end
				case (fault)
					FaultOverlong: begin
						if (len == 4)
							cp = {5'b0, cp[15:0]};
						else
							len = len + 1;
						send_char(cp, len, len, last);
					end
					FaultSurrogate: begin
						send_char(CpW'($urandom_range(SurrHi, SurrLo)), 3, 3, last);
					end
					FaultAboveMax: begin
						send_char(CpW'($urandom_range({CpW{1'b1}}, CpMax + 1)), 4, 4, last);
					end
					FaultLeader: begin
						b = $urandom_range(1) ? 8'($urandom_range(8'hBF, 8'h80))
							: 8'($urandom_range(8'hFF, 8'hF8));
						send_beat(b, last);
					end
					FaultContinuation: begin
						send_char(cp, len, int'($urandom_range(len - 1, 1)), 1'b0);
						b = 8'($urandom_range(255));
						if (b[7:6] == 2'b10)
							b[6] = 1'b1;
						send_beat(b, last);
					end
					FaultTruncate: begin
						send_char(cp, len, int'($urandom_range(len - 1, 1)), last);
					end
					default: begin
						send_char(cp, len, len, last);
					end
				endcase
			end
		end
	endtask

	task automatic run_random_traffic(input int unsigned send_pct, input int unsigned stall_pct,
		input logic pause_midway);
		int unsigned start;
		logic        paused;
		start = bytes_sent;
		paused = 1'b0;
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		while (bytes_sent - start < PhaseBytes) begin
			if (pause_midway && !paused && bytes_sent - start >= PhaseBytes / 2) begin
				wait_for_results();
				paused = 1'b1;
			end
			random_message();
		end
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_beat(8'h00, 1'b0);
		send_beat(8'h7F, 1'b1);
		send_beat(8'hC2, 1'b0);
		send_beat(8'h80, 1'b1);
		send_beat(8'hF4, 1'b0);
		send_beat(8'h8F, 1'b0);
		send_beat(8'hBF, 1'b0);
		send_beat(8'hBF, 1'b1);
		send_beat(8'hC0, 1'b0);
		send_beat(8'hAF, 1'b0);
		send_beat(8'h41, 1'b1);
		send_beat(8'hED, 1'b0);
		send_beat(8'hA0, 1'b0);
		send_beat(8'h80, 1'b1);
		send_beat(8'hFF, 1'b1);
		send_beat(8'h80, 1'b1);
		send_beat(8'hE0, 1'b0);
		send_beat(8'h41, 1'b1);
		send_beat(8'hF0, 1'b0);
		send_beat(8'h9F, 1'b1);
		send_beat(8'h20, 1'b0);
		send_beat(8'hDF, 1'b0);
		send_beat(8'hBF, 1'b1);
	endtask

	task automatic test_random_full_rate();
		run_random_traffic(0, 0, 1'b0);
	endtask

	task automatic test_random_sender_gaps();
		run_random_traffic(73, 0, 1'b1);
	endtask

	task automatic test_random_receiver_stalls();
		run_random_traffic(0, 73, 1'b0);
	endtask

	task automatic test_random_both_idle();
		run_random_traffic(35, 35, 1'b0);
	endtask

	initial begin
		arst_n = 1'b0;
		byte_in.valid = 1'b0;
		byte_in.data_byte = '0;
		byte_in.is_last = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		results_seen = 0;
		bytes_sent = 0;
		msgs_sent = 0;
		msgs_rejected = 0;
		msgs_control = 0;
		pend_cont = '0;
		cur_len = '0;
		cp_acc = '0;
		err_flag = 1'b0;
		ctl_flag = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_full_rate();
		test_random_sender_gaps();
		test_random_receiver_stalls();
		test_random_both_idle();

		wait_for_results();
		repeat (4) @(posedge clk);
		if (verdict_q.size() != 0)
			report_mismatch("expected results left over");

		$display("Covered %0d bytes in %0d messages: %0d rejected, %0d with control characters.",
			bytes_sent, msgs_sent, msgs_rejected, msgs_control);
		$display("Pacing: full rate, sender gaps, receiver stalls and both, with a full drain.");
		if (mismatches == 0)
			$display("utf8_validator_ctrl_detect_core_test: PASS");
		else
			$display("utf8_validator_ctrl_detect_core_test: FAIL");
		$finish;
	end

endmodule

/* files.f */
rtl/utf8v_pkg.sv
rtl/utf8v_in_if.sv
rtl/utf8v_out_if.sv
rtl/utf8v_step.sv
rtl/utf8_validator_ctrl_detect_core.sv
rtl/utf8v_checker.sv
sim/utf8_validator_ctrl_detect_core_test.sv
